/* sv/dmx_pkg.sv */
// ---------------------------------------------------------------------------
// dmx_pkg: shared types and constants of the surround downmix mixer
// Request and result payloads, stage control word, fixed-point widths.
// ---------------------------------------------------------------------------
package dmx_pkg;

    // Frame store geometry (power of two)
    localparam int FRAMES    = 256;
    localparam int IDX_W     = $clog2(FRAMES);

    // Fixed-point widths
    localparam int SAMPLE_W  = 24;
    localparam int GAIN_W    = 16;
    localparam int FIDX_W    = 8;
    localparam int STORE_W   = 30;
    localparam int ACC_W     = 32;
    localparam int OUT_W     = 16;

    // 0.708 in Q0.16
    localparam logic [15:0] MID_COEF = 16'd46399;

    // Mode codes
    localparam logic [1:0] MODE_SILENCE = 2'd0;
    localparam logic [1:0] MODE_STEREO  = 2'd1;
    localparam logic [1:0] MODE_SIX     = 2'd2;
    localparam logic [1:0] MODE_EIGHT   = 2'd3;

    // Port position codes
    localparam logic [1:0] POS_MIDDLE = 2'd0;
    localparam logic [1:0] POS_FIRST  = 2'd1;
    localparam logic [1:0] POS_LAST   = 2'd2;
    localparam logic [1:0] POS_ONLY   = 2'd3;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic        [1:0]          mode;
        logic        [FIDX_W-1:0]   frame_index;
        logic        [1:0]          port_position;
        logic        [GAIN_W-1:0]   port_gain;
        logic signed [SAMPLE_W-1:0] sample_left;
        logic signed [SAMPLE_W-1:0] sample_right;
        logic signed [SAMPLE_W-1:0] sample_center;
        logic signed [SAMPLE_W-1:0] sample_lfe;
        logic signed [SAMPLE_W-1:0] sample_rear_left;
        logic signed [SAMPLE_W-1:0] sample_rear_right;
        logic signed [SAMPLE_W-1:0] sample_side_left;
        logic signed [SAMPLE_W-1:0] sample_side_right;
    } t_in_req;

    typedef struct packed {
        logic        [FIDX_W-1:0] out_frame_index;
        logic signed [OUT_W-1:0]  mix_left;
        logic signed [OUT_W-1:0]  mix_right;
        logic                     clipped;
    } t_out_res;

    // Control word carried alongside the datapath stages
    typedef struct packed {
        logic              valid;
        logic [1:0]        mode;
        logic [1:0]        pos;
        logic [FIDX_W-1:0] fidx;
    } t_ctl;

endpackage

/* sv/dmx_if.sv */
// ---------------------------------------------------------------------------
// dmx_if: request and result channels of the downmix mixer
// Valid/ready channels; a request moves when valid and ready are both high.
// ---------------------------------------------------------------------------
interface dmx_in_if;
    import dmx_pkg::*;

    logic    valid;
    logic    ready;
    t_in_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dmx_out_if;
    import dmx_pkg::*;

    logic     valid;
    logic     ready;
    t_out_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/dmx_ram.sv */
// ---------------------------------------------------------------------------
// dmx_ram: generic single-write, single-read synchronous RAM
// One write port, one read port with registered read data and read enable.
// ---------------------------------------------------------------------------
module dmx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/dmx_scale.sv */
// ---------------------------------------------------------------------------
// dmx_scale: gain and fold-down pipeline of the downmix mixer
// Five stages: channel sums, gain products, mid partial products, mid
// rounding, side sum rounded to the store precision (Q.23).
// ---------------------------------------------------------------------------
module dmx_scale (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  dmx_pkg::t_in_req               i_req,
    output dmx_pkg::t_ctl                  o_next_ctl,
    output dmx_pkg::t_ctl                  o_ctl,
    output logic signed [dmx_pkg::STORE_W-1:0] o_left,
    output logic signed [dmx_pkg::STORE_W-1:0] o_right
);
    import dmx_pkg::*;

    // Stage control words
    t_ctl r_ctl_a, r_ctl_b, r_ctl_c, r_ctl_d, r_ctl_e;
    t_ctl n_ctl_a;

    // Stage A: channel sums and gain
    logic signed [24:0]       r_csum;
    logic signed [25:0]       r_lsum, r_rsum;
    logic        [GAIN_W-1:0] r_gain_a;
    logic signed [24:0]       n_csum;
    logic signed [25:0]       n_lsum, n_rsum;
    logic                     w_center_en, w_side_en;

    // Stage B: products
    logic signed [40:0]       r_p1;
    logic signed [42:0]       r_lprod_b, r_rprod_b;
    logic        [GAIN_W-1:0] r_gain_b;
    logic signed [41:0]       w_p1_full;
    logic signed [42:0]       w_lprod, w_rprod;

    // Stage C: mid partial products
    logic        [39:0]       r_lo_g;
    logic signed [33:0]       r_hi_g;
    logic signed [42:0]       r_lprod_c, r_rprod_c;

    // Stage D: rounded mid
    logic signed [41:0]       r_mid;
    logic signed [42:0]       r_lprod_d, r_rprod_d;
    logic signed [57:0]       w_mid_sum;

    // Stage E: store-precision side sums
    logic signed [STORE_W-1:0] r_left, r_right;
    logic signed [43:0]        w_lfull, w_rfull;

    // Enable folding per mode
    always_comb begin
        w_center_en = 1'b0;
        w_side_en   = 1'b0;
        case (i_req.mode)
            MODE_SIX: begin
                w_center_en = 1'b1;
            end
            MODE_EIGHT: begin
                w_center_en = 1'b1;
                w_side_en   = 1'b1;
            end
            default: begin
                w_center_en = 1'b0;
            end
        endcase
    end

    // Sum channels that share the gain
    always_comb begin
        n_csum = 25'sd0;
        n_lsum = 26'(i_req.sample_left);
        n_rsum = 26'(i_req.sample_right);
        if (w_center_en) begin
            n_csum = 25'(i_req.sample_center) + 25'(i_req.sample_lfe);
            n_lsum = n_lsum + 26'(i_req.sample_rear_left);
            n_rsum = n_rsum + 26'(i_req.sample_rear_right);
        end
        if (w_side_en) begin
            n_lsum = n_lsum + 26'(i_req.sample_side_left);
            n_rsum = n_rsum + 26'(i_req.sample_side_right);
        end
        n_ctl_a.valid = i_valid;
        n_ctl_a.mode  = i_req.mode;
        n_ctl_a.pos   = i_req.port_position;
        n_ctl_a.fidx  = i_req.frame_index;
    end

    // Gain and mid coefficient products
    assign w_p1_full = 42'(r_csum) * $signed({26'd0, MID_COEF});
    assign w_lprod   = 43'(r_lsum) * $signed({27'd0, r_gain_a});
    assign w_rprod   = 43'(r_rsum) * $signed({27'd0, r_gain_a});

    // Mid = round_half_up(p1 * gain / 2^16)
    assign w_mid_sum = $signed({r_hi_g, 24'd0}) + $signed({18'd0, r_lo_g})
                     + 58'sd32768;

    // Side sum, rounded half up to the store precision
    assign w_lfull = $signed({r_lprod_d[42], r_lprod_d})
                   + $signed({{2{r_mid[41]}}, r_mid}) + 44'sd8192;
    assign w_rfull = $signed({r_rprod_d[42], r_rprod_d})
                   + $signed({{2{r_mid[41]}}, r_mid}) + 44'sd8192;

    // Advance control words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
            r_ctl_b <= '0;
            r_ctl_c <= '0;
            r_ctl_d <= '0;
            r_ctl_e <= '0;
        end else if (i_en) begin
            r_ctl_a <= n_ctl_a;
            r_ctl_b <= r_ctl_a;
            r_ctl_c <= r_ctl_b;
            r_ctl_d <= r_ctl_c;
            r_ctl_e <= r_ctl_d;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_csum    <= n_csum;
            r_lsum    <= n_lsum;
            r_rsum    <= n_rsum;
            r_gain_a  <= i_req.port_gain;

            r_p1      <= w_p1_full[40:0];
            r_lprod_b <= w_lprod;
            r_rprod_b <= w_rprod;
            r_gain_b  <= r_gain_a;

            r_lo_g    <= r_p1[23:0] * {24'd0, r_gain_b};
            r_hi_g    <= 34'($signed(r_p1[40:24])) * $signed({18'd0, r_gain_b});
            r_lprod_c <= r_lprod_b;
            r_rprod_c <= r_rprod_b;

            r_mid     <= w_mid_sum[57:16];
            r_lprod_d <= r_lprod_c;
            r_rprod_d <= r_rprod_c;

            r_left    <= w_lfull[43:14];
            r_right   <= w_rfull[43:14];
        end
    end

    assign o_next_ctl = r_ctl_d;
    assign o_ctl      = r_ctl_e;
    assign o_left     = r_left;
    assign o_right    = r_right;

endmodule

/* sv/multichannel_downmix_mixer.sv */
// ---------------------------------------------------------------------------
// multichannel_downmix_mixer: surround-to-stereo downmix with frame store
// Folds one port frame to stereo and accumulates it per frame position.
// ---------------------------------------------------------------------------
// Usage:
//   i_req carries one port frame per request: mode, frame position, port
//   position, gain and eight samples. o_res returns one mixed 16-bit stereo
//   pair for every last port, only port and silence request; first and
//   middle ports of other modes return nothing.
//   A new request is taken every cycle unless a stalled receiver holds the
//   pipeline. A request passes five scaling stages, one read-modify-write
//   stage on the frame store and one output rounding stage to its result.
//   The frame store is one 256 x 64 RAM with a registered read. A write and
//   the read of the next request to the same frame position fall in the
//   same cycle; the last written entry is forwarded to cover it.
//   Reset clears the pipeline and the output valid; the frame store is not
//   cleared, so a first or only port must open each frame position.
//   When the receiver stalls with a result pending, the whole pipeline
//   holds and i_req.ready drops in the same cycle.
// ---------------------------------------------------------------------------
module multichannel_downmix_mixer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dmx_in_if.sink     i_req,
    dmx_out_if.source  o_res
);
    import dmx_pkg::*;

    // Round half to even by 2^8 and saturate to 16 bits; bit 16 flags clip
    function automatic logic [OUT_W:0] to_out(input logic signed [ACC_W-1:0] a);
        logic signed [23:0] q;
        logic               up;
        logic signed [24:0] qr;
        logic [OUT_W:0]     res;
        q  = a[31:8];
        up = a[7] && ((a[6:0] != 7'd0) || q[0]);
        qr = 25'(q) + $signed({24'd0, up});
        if (qr > 25'sd32767) begin
            res = {1'b1, 16'h7FFF};
        end else if (qr < -25'sd32768) begin
            res = {1'b1, 16'h8000};
        end else begin
            res = {1'b0, qr[15:0]};
        end
        return res;
    endfunction

    // Saturating add to the signed 32-bit range
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]   base,
        input logic signed [STORE_W-1:0] inc
    );
        logic signed [ACC_W:0] s;
        logic signed [ACC_W-1:0] res;
        s = 33'(base) + 33'(inc);
        if (s > 33'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (s < -33'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = s[31:0];
        end
        return res;
    endfunction

    logic                      w_adv;
    t_ctl                      w_next_ctl, w_e_ctl;
    logic signed [STORE_W-1:0] w_e_left, w_e_right;

    // Frame store access
    logic                      w_we;
    t_idx                      w_e_idx;
    logic [2*ACC_W-1:0]        w_rdata, w_wdata, w_entry;
    logic signed [ACC_W-1:0]   w_base_l, w_base_r, w_acc_l, w_acc_r;
    logic                      w_emit;

    // Forwarding of the last write
    logic                      r_fwd_we;
    t_idx                      r_fwd_idx;
    logic [2*ACC_W-1:0]        r_fwd_data;

    // Accumulate stage
    t_ctl                      r_f_ctl;
    logic                      r_f_emit;
    logic signed [ACC_W-1:0]   r_f_left, r_f_right;

    // Output register
    logic                      r_out_valid;
    t_out_res                  r_out;
    logic [OUT_W:0]            w_ol, w_or;

    // Hold everything while a result waits on a stalled receiver
    assign w_adv       = !r_out_valid || o_res.ready;
    assign i_req.ready = w_adv;

    dmx_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_valid    (i_req.valid),
        .i_req      (i_req.data),
        .o_next_ctl (w_next_ctl),
        .o_ctl      (w_e_ctl),
        .o_left     (w_e_left),
        .o_right    (w_e_right)
    );

    assign w_e_idx = IDX_W'(w_e_ctl.fidx);
    assign w_we    = w_adv && w_e_ctl.valid && (w_e_ctl.mode != MODE_SILENCE);

    dmx_ram #(
        .WIDTH (2*ACC_W),
        .DEPTH (FRAMES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_e_idx),
        .i_wdata (w_wdata),
        .i_re    (w_adv),
        .i_raddr (IDX_W'(w_next_ctl.fidx)),
        .o_rdata (w_rdata)
    );

    // Select the accumulator base: zero on an opening port, else the entry
    always_comb begin
        w_entry = (r_fwd_we && (r_fwd_idx == w_e_idx)) ? r_fwd_data : w_rdata;
        case (w_e_ctl.pos) inside
            POS_FIRST, POS_ONLY: begin
                w_base_l = '0;
                w_base_r = '0;
            end
            default: begin
                w_base_l = w_entry[ACC_W-1:0];
                w_base_r = w_entry[2*ACC_W-1:ACC_W];
            end
        endcase
        w_acc_l = sat_add(w_base_l, w_e_left);
        w_acc_r = sat_add(w_base_r, w_e_right);
        w_wdata = {w_acc_r, w_acc_l};
        case (w_e_ctl.pos) inside
            POS_LAST, POS_ONLY: w_emit = 1'b1;
            default:            w_emit = (w_e_ctl.mode == MODE_SILENCE);
        endcase
    end

    // Track the last write for forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_we <= 1'b0;
        end else if (w_adv) begin
            r_fwd_we <= w_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fwd_idx  <= w_e_idx;
            r_fwd_data <= w_wdata;
        end
    end

    // Register accumulated pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_ctl  <= '0;
            r_f_emit <= 1'b0;
        end else if (w_adv) begin
            r_f_ctl  <= w_e_ctl;
            r_f_emit <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f_left  <= w_acc_l;
            r_f_right <= w_acc_r;
        end
    end

    // Round and saturate into the output register
    assign w_ol = to_out(r_f_left);
    assign w_or = to_out(r_f_right);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_f_ctl.valid && r_f_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.out_frame_index <= r_f_ctl.fidx;
            if (r_f_ctl.mode == MODE_SILENCE) begin
                r_out.mix_left  <= '0;
                r_out.mix_right <= '0;
                r_out.clipped   <= 1'b0;
            end else begin
                r_out.mix_left  <= w_ol[OUT_W-1:0];
                r_out.mix_right <= w_or[OUT_W-1:0];
                r_out.clipped   <= w_ol[OUT_W] || w_or[OUT_W];
            end
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // No store write while the pipeline holds
    a_write_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> w_adv)
        else $error("frame store written during a stall");

    // A silence request yields a zero pair
    a_silence_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_f_ctl.valid && (r_f_ctl.mode == MODE_SILENCE)) |=>
        (o_res.valid && (o_res.data.mix_left == 16'sd0) &&
         (o_res.data.mix_right == 16'sd0) && !o_res.data.clipped))
        else $error("silence request produced a nonzero result");

    // Clip flag only with a full-scale channel
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.clipped) |->
        ((o_res.data.mix_left == 16'sh7FFF) || (o_res.data.mix_left == 16'sh8000) ||
         (o_res.data.mix_right == 16'sh7FFF) || (o_res.data.mix_right == 16'sh8000)))
        else $error("clip flag set without a saturated channel");

endmodule
